// File: src/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg - shared types and constants for the turtle pen stepper
// Operation codes, register indexes, sequencer states, the CORDIC arctangent
// constants and the constants of the turn-step reciprocal divide.
// ----------------------------------------------------------------------------
package tps_pkg;

  typedef enum logic [2:0] {
    OP_MOVE_H  = 3'd0,
    OP_MOVE_V  = 3'd1,
    OP_TURN_L  = 3'd2,
    OP_TURN_R  = 3'd3,
    OP_CENTER  = 3'd4,
    OP_COLOR   = 3'd5,
    OP_RELOAD  = 3'd6,
    OP_NOP     = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    CFG_START_H       = 3'd0,
    CFG_START_V       = 3'd1,
    CFG_START_HEADING = 3'd2,
    CFG_START_RED     = 3'd3,
    CFG_START_GREEN   = 3'd4,
    CFG_START_BLUE    = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APPLY,
    ST_TRIG,
    ST_MUL,
    ST_RND,
    ST_ADD,
    ST_DIV,
    ST_TMUL,
    ST_TURN,
    ST_DONE
  } state_e;

  // CORDIC gain compensation 0.60725293500888 in Q30
  localparam longint K_Q30 = 64'sd652032874;

  // atan(2^-i) in binary-angle units (2^32 per turn)
  localparam int unsigned ATAN_DEPTH = 31;
  localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1
  };

  // Turn step: |deg| * 2^32 / 360 = |deg| * TURN_SCALE + (|deg|*256 + 180) / 360.
  // The fractional part reduces to (|deg|*32 + 22) / 45.
  localparam logic [23:0] TURN_SCALE = 24'd11930464;
  localparam int unsigned TURN_NW    = 21;   // dividend width
  localparam int unsigned TURN_QW    = 15;   // quotient width
  localparam logic [TURN_NW-1:0] TURN_BIAS = 21'd22;
  // n / 45 as (n * TURN_RECIP) >> TURN_RSH, exact for every n below 2^TURN_NW
  localparam int unsigned        TURN_RW    = 22;
  localparam logic [TURN_RW-1:0] TURN_RECIP = 22'd2982617;
  localparam int unsigned        TURN_RSH   = 27;

endpackage

// File: src/tps_cordic.sv
// ----------------------------------------------------------------------------
// tps_cordic - iterative rotation-mode CORDIC
// One add/subtract/shift stage reused over CORDIC_STEPS iterations; the quadrant
// is folded back in on the output.
// ----------------------------------------------------------------------------
module tps_cordic #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16,
  parameter int XW           = 19
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [31:0]          angle_i,
  output logic                 done_o,
  output logic signed [XW-1:0] cos_o,
  output logic signed [XW-1:0] sin_o
);
  import tps_pkg::*;

  localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam longint X0 = (K_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);

  logic signed [XW-1:0] x_q, x_d, y_q, y_d;
  logic signed [31:0]   z_q, z_d;
  logic [1:0]           quad_q;
  logic [CW-1:0]        cnt_q;
  logic                 busy_q, done_q;
  logic signed [XW-1:0] dx, dy;
  logic signed [31:0]   atan_v;

  always_comb begin
    dx     = x_q;
    dy     = y_q;
    dx     = y_q >>> cnt_q;
    dy     = x_q >>> cnt_q;
    atan_v = signed'(ATAN_TAB[5'(cnt_q)]);
    if (!z_q[31]) begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - atan_v;
    end else begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + atan_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= XW'(X0);
      y_q    <= '0;
      z_q    <= signed'({2'b00, angle_i[29:0]});
      quad_q <= angle_i[31:30];
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  // rotate by the quadrant's multiple of 90 degrees
  always_comb begin
    unique case (quad_q)
      2'd0: begin cos_o = x_q;  sin_o = y_q;  end
      2'd1: begin cos_o = -y_q; sin_o = x_q;  end
      2'd2: begin cos_o = -x_q; sin_o = -y_q; end
      default: begin cos_o = y_q; sin_o = -x_q; end
    endcase
  end

  assign done_o = done_q;

endmodule

// File: src/tps_turn_div.sv
// ----------------------------------------------------------------------------
// tps_turn_div - divide by a constant through a reciprocal multiply
// Gives the fractional part of the turn step in the cycle after the operand is
// captured.
// ----------------------------------------------------------------------------
module tps_turn_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tps_pkg::TURN_NW-1:0]  dividend_i,
  output logic                         done_o,
  output logic [tps_pkg::TURN_QW-1:0]  quot_o
);
  import tps_pkg::*;

  localparam int PROD_W = TURN_NW + TURN_RW;

  logic [TURN_NW-1:0] num_q;
  logic [PROD_W-1:0]  prod;
  logic [TURN_QW-1:0] quot_q;
  logic               busy_q, done_q;

  assign prod = PROD_W'(num_q) * PROD_W'(TURN_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) num_q  <= dividend_i;
    if (busy_q)  quot_q <= prod[TURN_RSH +: TURN_QW];
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: src/turtle_pen_stepper.sv
// ----------------------------------------------------------------------------
// turtle_pen_stepper - fixed-point turtle-graphics pen
// Sequencer, pen state, move multiplier and saturation, turn update.
// ----------------------------------------------------------------------------
// A pen with a Q16.16 horizontal and vertical position, a binary-angle
// heading (2^32 per turn) and an RGB color. Each input transfer carries one
// operation and returns exactly one output transfer with the full pen state.
// Moves run the iterative CORDIC, one iteration per clock, followed by a
// multiply, a rounding stage and the saturating add. For turns a reciprocal
// multiply gives the rounded fraction of deg*2^32/360, then the whole-degree
// product and the heading update follow. Center, color, reload and the
// unused code pass only through the apply state. One item is in work at a
// time; in_stall_o is high while it is. The result sits in an output
// register, so the next input is taken while a result still waits.
// Config writes (cfg_ready_o is always high) only change the start registers;
// the pen picks them up on a reload. Writes to index 6 and up are dropped.
// ----------------------------------------------------------------------------
module turtle_pen_stepper #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic signed [15:0] amount_i,
  input  logic signed [15:0] coord_h_i,
  input  logic signed [15:0] coord_v_i,
  input  logic [7:0]         red_in_i,
  input  logic [7:0]         green_in_i,
  input  logic [7:0]         blue_in_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_h_o,
  output logic signed [31:0] pos_v_o,
  output logic [31:0]        heading_out_o,
  output logic [7:0]         red_out_o,
  output logic [7:0]         green_out_o,
  output logic [7:0]         blue_out_o,
  output logic               saturated_o,
  // config write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import tps_pkg::*;

  localparam int POS_FRAC = 16;
  localparam int XW   = FRAC_BITS + 3;              // cos/sin width
  localparam int PW   = 16 + XW;                    // amount * trig
  localparam int DW   = PW + 9;                     // delta / sum width
  localparam int SH_R = (FRAC_BITS >= POS_FRAC) ? FRAC_BITS - POS_FRAC : 0;
  localparam int SH_L = (FRAC_BITS <  POS_FRAC) ? POS_FRAC - FRAC_BITS : 0;
  localparam logic signed [DW-1:0] HALF    = DW'((64'sd1 <<< SH_R) >>> 1);
  localparam logic signed [DW-1:0] POS_MAX = DW'(64'sd2147483647);
  localparam logic signed [DW-1:0] POS_MIN = DW'(-64'sd2147483648);

  // --------------------------------------------------------------------------
  // config registers
  // --------------------------------------------------------------------------
  logic signed [31:0] start_h_q, start_v_q;
  logic [31:0]        start_heading_q;
  logic [7:0]         start_red_q, start_green_q, start_blue_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_h_q       <= '0;
      start_v_q       <= '0;
      start_heading_q <= '0;
      start_red_q     <= '0;
      start_green_q   <= '0;
      start_blue_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_START_H:       start_h_q       <= signed'(cfg_data_i);
        CFG_START_V:       start_v_q       <= signed'(cfg_data_i);
        CFG_START_HEADING: start_heading_q <= cfg_data_i;
        CFG_START_RED:     start_red_q     <= cfg_data_i[7:0];
        CFG_START_GREEN:   start_green_q   <= cfg_data_i[7:0];
        CFG_START_BLUE:    start_blue_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  state_e state_q, state_d;
  logic   in_acc, out_load, out_valid_q, out_valid_d;
  logic   cordic_start, cordic_done, div_start, div_done;
  op_e    op_in, op_q;

  assign op_in  = op_e'(operation_i);
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (op_in == OP_MOVE_H || op_in == OP_MOVE_V)      state_d = ST_TRIG;
          else if (op_in == OP_TURN_L || op_in == OP_TURN_R) state_d = ST_DIV;
          else                                               state_d = ST_APPLY;
        end
      end
      ST_APPLY: state_d = ST_DONE;
      ST_TRIG:  if (cordic_done) state_d = ST_MUL;
      ST_MUL:   state_d = ST_RND;
      ST_RND:   state_d = ST_ADD;
      ST_ADD:   state_d = ST_DONE;
      ST_DIV:   if (div_done) state_d = ST_TMUL;
      ST_TMUL:  state_d = ST_TURN;
      ST_TURN:  state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o   = (state_q != ST_IDLE);
    cordic_start = 1'b0;
    div_start    = 1'b0;
    if (state_q == ST_IDLE && in_valid_i) begin
      cordic_start = (op_in == OP_MOVE_H || op_in == OP_MOVE_V);
      div_start    = (op_in == OP_TURN_L || op_in == OP_TURN_R);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (out_load)                    out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // --------------------------------------------------------------------------
  // captured input item
  // --------------------------------------------------------------------------
  logic signed [15:0] amount_q, coord_h_q, coord_v_q;
  logic [7:0]         red_q, green_q, blue_q;
  logic [15:0]        mag_in, mag_q;

  assign mag_in = amount_i[15] ? 16'(-amount_i) : amount_i;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q      <= op_in;
      amount_q  <= amount_i;
      mag_q     <= mag_in;
      coord_h_q <= coord_h_i;
      coord_v_q <= coord_v_i;
      red_q     <= red_in_i;
      green_q   <= green_in_i;
      blue_q    <= blue_in_i;
    end
  end

  // --------------------------------------------------------------------------
  // iterative units
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] cos_v, sin_v;
  logic [TURN_QW-1:0]   quot;
  logic [31:0]          heading_q;

  tps_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .FRAC_BITS    (FRAC_BITS),
    .XW           (XW)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (heading_q),
    .done_o  (cordic_done),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  tps_turn_div u_turn_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({mag_in, 5'd0} + TURN_BIAS),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // --------------------------------------------------------------------------
  // move datapath: multiply, round to Q16, saturating add
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] trig_sel;
  logic signed [PW-1:0] prod_q;
  logic signed [DW-1:0] delta_d, delta_q, pen_sel, sum;
  logic signed [31:0]   pen_h_q, pen_v_q, sum_sat;
  logic                 clip, sat_q;
  logic [31:0]          step_q, step_signed;

  assign trig_sel = (op_q == OP_MOVE_H) ? cos_v : sin_v;
  // round half up on a floor shift, or exact widen when FRAC_BITS < 16
  assign delta_d  = ((DW'(prod_q) + HALF) >>> SH_R) <<< SH_L;
  assign pen_sel  = (op_q == OP_MOVE_H) ? DW'(pen_h_q) : DW'(pen_v_q);
  assign sum      = pen_sel + delta_q;

  always_comb begin
    clip    = 1'b1;
    if (sum > POS_MAX)      sum_sat = 32'sh7FFF_FFFF;
    else if (sum < POS_MIN) sum_sat = 32'sh8000_0000;
    else begin
      sum_sat = sum[31:0];
      clip    = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL)  prod_q  <= amount_q * trig_sel;
    if (state_q == ST_RND)  delta_q <= delta_d;
    // integer part times TURN_SCALE plus the rounded fraction, mod 2^32
    if (state_q == ST_TMUL) step_q  <= 32'((40'(mag_q) * 40'(TURN_SCALE)) + 40'(quot));
  end

  assign step_signed = amount_q[15] ? (32'd0 - step_q) : step_q;

  // --------------------------------------------------------------------------
  // pen state
  // --------------------------------------------------------------------------
  logic [7:0] pen_red_q, pen_green_q, pen_blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_h_q     <= '0;
      pen_v_q     <= '0;
      heading_q   <= '0;
      pen_red_q   <= '0;
      pen_green_q <= '0;
      pen_blue_q  <= '0;
      sat_q       <= 1'b0;
    end else begin
      if (in_acc) sat_q <= 1'b0;
      unique case (state_q)
        ST_APPLY: begin
          if (op_q == OP_CENTER) begin
            pen_h_q <= {coord_h_q, 16'd0};
            pen_v_q <= {coord_v_q, 16'd0};
          end else if (op_q == OP_COLOR) begin
            pen_red_q   <= red_q;
            pen_green_q <= green_q;
            pen_blue_q  <= blue_q;
          end else if (op_q == OP_RELOAD) begin
            pen_h_q     <= start_h_q;
            pen_v_q     <= start_v_q;
            heading_q   <= start_heading_q;
            pen_red_q   <= start_red_q;
            pen_green_q <= start_green_q;
            pen_blue_q  <= start_blue_q;
          end
        end
        ST_ADD: begin
          if (op_q == OP_MOVE_H) pen_h_q <= sum_sat;
          else                   pen_v_q <= sum_sat;
          sat_q <= clip;
        end
        ST_TURN: begin
          if (op_q == OP_TURN_L) heading_q <= heading_q - step_signed;
          else                   heading_q <= heading_q + step_signed;
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pos_h_o       <= pen_h_q;
      pos_v_o       <= pen_v_q;
      heading_out_o <= heading_q;
      red_out_o     <= pen_red_q;
      green_out_o   <= pen_green_q;
      blue_out_o    <= pen_blue_q;
      saturated_o   <= sat_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result presented without finishing an item");

  a_cordic_in_trig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_done |-> (state_q == ST_TRIG))
    else $error("CORDIC finished outside a move");

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("turn divider finished outside a turn");

  a_sat_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (pos_h_o == 32'sh7FFF_FFFF || pos_h_o == 32'sh8000_0000 ||
       pos_v_o == 32'sh7FFF_FFFF || pos_v_o == 32'sh8000_0000))
    else $error("saturation flagged with no position at a rail");

endmodule

// File: tb/sv/tps_pen_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_pen_checker - result checker for the turtle pen stepper
// Follows the config, input and output channels. It keeps its own copy of
// the pen and of the start registers and works out the pen state that each
// command should produce. Each returned state is compared against the oldest
// one that is still outstanding.
// ----------------------------------------------------------------------------
module tps_pen_checker #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         operation_i,
  input  logic signed [15:0] amount_i,
  input  logic signed [15:0] coord_h_i,
  input  logic signed [15:0] coord_v_i,
  input  logic [7:0]         red_in_i,
  input  logic [7:0]         green_in_i,
  input  logic [7:0]         blue_in_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] pos_h_i,
  input  logic signed [31:0] pos_v_i,
  input  logic [31:0]        heading_out_i,
  input  logic [7:0]         red_out_i,
  input  logic [7:0]         green_out_i,
  input  logic [7:0]         blue_out_i,
  input  logic               saturated_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int                 mismatches_o,
  output int                 pending_o
);
  import tps_pkg::*;

  localparam longint POS_MAX     = 64'sd2147483647;
  localparam longint POS_MIN     = -64'sd2147483648;
  localparam int     MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [31:0] pos_h;
    logic signed [31:0] pos_v;
    logic [31:0]        heading;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               saturated;
  } pen_state_t;

  // pen copy and start ("home") registers
  logic signed [31:0] h_pos, v_pos, home_h, home_v;
  logic [31:0]        hdg, home_hdg;
  logic [7:0]         ink_r, ink_g, ink_b, home_r, home_g, home_b;

  pen_state_t pen_states_due[$];
  int         n_bad;

  // Applies one command to the pen copy and returns the state it leaves.
  function automatic pen_state_t advance_pen(input op_e op, input logic signed [15:0] amt,
                                             input logic signed [15:0] ch, cv,
                                             input logic [7:0] r, g, b);
    longint            x, y, z, dx, dy, cos_v, sin_v, prod, delta, sum, a;
    longint unsigned   mag, quo;
    logic [31:0]       turn;
    logic              clip;
    int                sh;
    pen_state_t        res;
    clip = 1'b0;
    case (op)
      OP_MOVE_H, OP_MOVE_V: begin
        // CORDIC on the angle within the quadrant, start vector (K, 0)
        z = longint'({34'd0, hdg[29:0]});
        x = (K_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < int'(ATAN_DEPTH); i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'({32'd0, ATAN_TAB[i]});
          end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'({32'd0, ATAN_TAB[i]});
          end
        end
        case (hdg[31:30])
          2'd0: begin cos_v = x;  sin_v = y;  end
          2'd1: begin cos_v = -y; sin_v = x;  end
          2'd2: begin cos_v = -x; sin_v = -y; end
          default: begin cos_v = y; sin_v = -x; end
        endcase
        prod = longint'(amt) * ((op == OP_MOVE_H) ? cos_v : sin_v);
        sh = FRAC_BITS - 16;
        if (sh > 0) delta = (prod + (64'sd1 <<< (sh - 1))) >>> sh;
        else delta = prod <<< (-sh);
        sum = ((op == OP_MOVE_H) ? longint'(h_pos) : longint'(v_pos)) + delta;
        if (sum > POS_MAX) begin
          sum  = POS_MAX;
          clip = 1'b1;
        end else if (sum < POS_MIN) begin
          sum  = POS_MIN;
          clip = 1'b1;
        end
        if (op == OP_MOVE_H) h_pos = 32'(sum);
        else v_pos = 32'(sum);
      end
      OP_TURN_L, OP_TURN_R: begin
        // rounded |deg| * 2^32 / 360, ties away from zero, then signed
        a    = longint'(amt);
        mag  = (a < 0) ? longint'(-a) : a;
        quo  = ((mag << 32) + 64'd180) / 64'd360;
        turn = quo[31:0];
        if (a < 0) turn = 32'd0 - turn;
        hdg = (op == OP_TURN_L) ? hdg - turn : hdg + turn;
      end
      OP_CENTER: begin
        h_pos = {ch, 16'h0000};
        v_pos = {cv, 16'h0000};
      end
      OP_COLOR: begin
        ink_r = r;
        ink_g = g;
        ink_b = b;
      end
      OP_RELOAD: begin
        h_pos = home_h;
        v_pos = home_v;
        hdg   = home_hdg;
        ink_r = home_r;
        ink_g = home_g;
        ink_b = home_b;
      end
      default: ;
    endcase
    res = '{h_pos, v_pos, hdg, ink_r, ink_g, ink_b, clip};
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    pen_state_t got, want;
    if (!rst_ni) begin
      h_pos    = '0;
      v_pos    = '0;
      hdg      = '0;
      ink_r    = '0;
      ink_g    = '0;
      ink_b    = '0;
      home_h   = '0;
      home_v   = '0;
      home_hdg = '0;
      home_r   = '0;
      home_g   = '0;
      home_b   = '0;
      n_bad    = 0;
      pen_states_due.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{pos_h_i, pos_v_i, heading_out_i, red_out_i, green_out_i, blue_out_i,
                saturated_i};
        if (pen_states_due.size() == 0) begin
          if (n_bad < MAX_REPORTS)
            $display("[%0t] result transfer with no command outstanding", $time);
          n_bad++;
        end else begin
          want = pen_states_due.pop_front();
          if (got !== want) begin
            if (n_bad < MAX_REPORTS) begin
              $display("[%0t] pen state mismatch", $time);
              $display("  exp h=%0d v=%0d hdg=%h rgb=%h/%h/%h sat=%b", want.pos_h,
                       want.pos_v, want.heading, want.red, want.green, want.blue,
                       want.saturated);
              $display("  got h=%0d v=%0d hdg=%h rgb=%h/%h/%h sat=%b", got.pos_h,
                       got.pos_v, got.heading, got.red, got.green, got.blue,
                       got.saturated);
            end
            n_bad++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_START_H:       home_h   = cfg_data_i;
          CFG_START_V:       home_v   = cfg_data_i;
          CFG_START_HEADING: home_hdg = cfg_data_i;
          CFG_START_RED:     home_r   = cfg_data_i[7:0];
          CFG_START_GREEN:   home_g   = cfg_data_i[7:0];
          CFG_START_BLUE:    home_b   = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        pen_states_due.push_back(advance_pen(op_e'(operation_i), amount_i, coord_h_i,
                                             coord_v_i, red_in_i, green_in_i, blue_in_i));
      mismatches_o <= n_bad;
      pending_o    <= pen_states_due.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the turtle pen stepper
// Drives pen commands and start-register writes into the block, stalls the
// result side, and leaves prediction and comparison to tps_pen_checker.
// A directed opening covers range limits, every operation, clipping in both
// directions, all four heading quadrants and the unused operation code; six
// phases of random commands follow, each after a new set of start registers.
// ----------------------------------------------------------------------------
module tb_top;
  import tps_pkg::*;

  localparam int CORDIC_STEPS    = 16;
  localparam int FRAC_BITS       = 16;
  localparam int HALF_PERIOD     = 6;     // 12 ns clock
  localparam int RESET_CYCLES    = 6;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 72;
  localparam int HOLD_LEN        = 250;   // long result-side back-pressure
  localparam int QUIET_LIMIT     = 4000;  // cycles without any transfer
  localparam int SETTLE_CYCLES   = 40;    // longer than a move takes from input to result

  // first register index the block does not decode
  localparam logic [2:0] CFG_IDX_UNUSED = 3'd6;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid, in_stall;
  logic [2:0]         operation;
  logic signed [15:0] amount, coord_h, coord_v;
  logic [7:0]         red_in, green_in, blue_in;
  logic               out_valid, out_stall;
  logic signed [31:0] pos_h, pos_v;
  logic [31:0]        heading_out;
  logic [7:0]         red_out, green_out, blue_out;
  logic               saturated;
  logic               cfg_valid, cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  int                 n_mismatch, n_pending;

  // sender burst bookkeeping and long-stall request counter
  int burst_left;
  int hold_seq;

  always #HALF_PERIOD clk = ~clk;

  turtle_pen_stepper #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .FRAC_BITS    (FRAC_BITS)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (operation),
    .amount_i      (amount),
    .coord_h_i     (coord_h),
    .coord_v_i     (coord_v),
    .red_in_i      (red_in),
    .green_in_i    (green_in),
    .blue_in_i     (blue_in),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .pos_h_o       (pos_h),
    .pos_v_o       (pos_v),
    .heading_out_o (heading_out),
    .red_out_o     (red_out),
    .green_out_o   (green_out),
    .blue_out_o    (blue_out),
    .saturated_o   (saturated),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  tps_pen_checker #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .FRAC_BITS    (FRAC_BITS)
  ) i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .operation_i   (operation),
    .amount_i      (amount),
    .coord_h_i     (coord_h),
    .coord_v_i     (coord_v),
    .red_in_i      (red_in),
    .green_in_i    (green_in),
    .blue_in_i     (blue_in),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .pos_h_i       (pos_h),
    .pos_v_i       (pos_v),
    .heading_out_i (heading_out),
    .red_out_i     (red_out),
    .green_out_i   (green_out),
    .blue_out_i    (blue_out),
    .saturated_i   (saturated),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (n_mismatch),
    .pending_o     (n_pending)
  );

  // --------------------------------------------------------------------------
  // Result side. Stalls follow a random duty that is redrawn after a run of
  // random length (0 % gives stretches with no stall at all). A bump of hold_seq
  // from the stimulus holds stall high for a long hold set by HOLD_LEN so the
  // output register and the work stage both fill and in_stall goes high.
  // --------------------------------------------------------------------------
  int hold_left, hold_seen, duty_left, stall_pct;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
      duty_left <= 0;
      stall_pct <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else begin
      if (duty_left == 0) begin
        duty_left <= $urandom_range(20, 120);
        case ($urandom_range(3))
          0:       stall_pct <= 0;
          1:       stall_pct <= 15;
          2:       stall_pct <= 50;
          default: stall_pct <= 85;
        endcase
      end else begin
        duty_left <= duty_left - 1;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any transfer on any channel counts as progress.
  // --------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) quiet_cycles <= 0;
    else if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("FAIL turtle_pen_stepper");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. All of them are entered and left right after a rising
  // edge; the payload holds until the transfer, then may change at once.
  // --------------------------------------------------------------------------

  // Offers one command and waits for its transfer. At the end of a burst the
  // sender drops valid for a random gap; a third of the bursts run straight
  // into the next one.
  task automatic offer_cmd(input op_e op, input logic [15:0] amt, ch, cv,
                           input logic [7:0] r, g, b);
    int gap;
    in_valid  <= 1'b1;
    operation <= op;
    amount    <= amt;
    coord_h   <= ch;
    coord_v   <= cv;
    red_in    <= r;
    green_in  <= g;
    blue_in   <= b;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(2) == 0) ? 0
          : $urandom_range(1, ($urandom_range(7) == 0) ? 40 : 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops offering and waits until every issued command has its result.
  // n_pending is registered and lags, so the first look waits for a clock edge.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  // One config transfer; cfg_valid is left high for back-to-back writes.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Rewrites all start registers, with a write to an undecoded index in
  // the middle that must leave everything untouched.
  task automatic program_home(input logic [31:0] h, v, hdg, input logic [7:0] r, g, b);
    write_reg(CFG_START_H, h);
    write_reg(CFG_START_V, v);
    write_reg(CFG_START_HEADING, hdg);
    write_reg(CFG_IDX_UNUSED + 3'($urandom_range(1)), $urandom);
    write_reg(CFG_START_RED, {24'($urandom), r});
    write_reg(CFG_START_GREEN, {24'($urandom), g});
    write_reg(CFG_START_BLUE, {24'($urandom), b});
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    op_e         op;
    logic [15:0] amt;
    int          sel;

    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    operation  <= OP_NOP;
    amount     <= '0;
    coord_h    <= '0;
    coord_v    <= '0;
    red_in     <= '0;
    green_in   <= '0;
    blue_in    <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_START_H;
    cfg_data   <= '0;
    hold_seq   <= 0;
    burst_left = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening, start registers still at reset (all zero).
    // Unused code on the fresh pen, then full-scale moves along heading 0
    // until the horizontal position clips high and then low.
    offer_cmd(OP_NOP,    16'h0000, '0, '0, '0, '0, '0);
    offer_cmd(OP_MOVE_H, 16'h7FFF, '0, '0, '0, '0, '0);
    offer_cmd(OP_MOVE_H, 16'h7FFF, '0, '0, '0, '0, '0);
    offer_cmd(OP_MOVE_H, 16'h8000, '0, '0, '0, '0, '0);
    offer_cmd(OP_MOVE_H, 16'h8000, '0, '0, '0, '0, '0);
    offer_cmd(OP_MOVE_H, 16'h8000, '0, '0, '0, '0, '0);
    // sine near zero at heading 0
    offer_cmd(OP_MOVE_V, 16'h0001, '0, '0, '0, '0, '0);
    // quadrant 1, vertical clipping
    offer_cmd(OP_TURN_R, 16'd90,   '0, '0, '0, '0, '0);
    offer_cmd(OP_MOVE_V, 16'h7FFF, '0, '0, '0, '0, '0);
    offer_cmd(OP_MOVE_V, 16'h7FFF, '0, '0, '0, '0, '0);
    // quadrant 2
    offer_cmd(OP_TURN_R, 16'd100,  '0, '0, '0, '0, '0);
    offer_cmd(OP_MOVE_H, 16'hFFFF, '0, '0, '0, '0, '0);
    offer_cmd(OP_MOVE_V, 16'd7,    '0, '0, '0, '0, '0);
    // turn extremes: negative left, largest right, zero
    offer_cmd(OP_TURN_L, 16'h8000, '0, '0, '0, '0, '0);
    offer_cmd(OP_TURN_R, 16'h7FFF, '0, '0, '0, '0, '0);
    offer_cmd(OP_TURN_L, 16'h0000, '0, '0, '0, '0, '0);
    // quadrant 3
    offer_cmd(OP_TURN_R, 16'd135,  '0, '0, '0, '0, '0);
    offer_cmd(OP_MOVE_H, 16'd12345,  '0, '0, '0, '0, '0);
    offer_cmd(OP_MOVE_V, -16'sd12345, '0, '0, '0, '0, '0);
    // center and color at their limits, both polarities
    offer_cmd(OP_CENTER, '0, 16'h8000, 16'h7FFF, '0, '0, '0);
    offer_cmd(OP_CENTER, '0, 16'h7FFF, 16'h8000, '0, '0, '0);
    offer_cmd(OP_COLOR,  '0, '0, '0, 8'hFF, 8'h00, 8'hFF);
    offer_cmd(OP_COLOR,  '0, '0, '0, 8'h00, 8'hFF, 8'h00);
    offer_cmd(OP_RELOAD, '0, '0, '0, '0, '0, '0);
    offer_cmd(OP_NOP,    16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    drain();

    // Random phases. Start registers are only touched with the block idle.
    // Each phase opens with a reload so the new start point is used at once.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_home(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 8'hFF, 8'h00, 8'hFF);
        1: program_home(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 8'h00, 8'hFF, 8'h00);
        default: program_home($urandom, $urandom, $urandom, 8'($urandom), 8'($urandom),
                              8'($urandom));
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // one long result-side hold while commands keep coming
        if (ph == 2 && n == 12) hold_seq <= hold_seq + 1;
        sel = $urandom_range(99);
        if (n == 0)        op = OP_RELOAD;
        else if (sel < 22) op = OP_MOVE_H;
        else if (sel < 44) op = OP_MOVE_V;
        else if (sel < 57) op = OP_TURN_L;
        else if (sel < 70) op = OP_TURN_R;
        else if (sel < 78) op = OP_CENTER;
        else if (sel < 86) op = OP_COLOR;
        else if (sel < 95) op = OP_RELOAD;
        else               op = OP_NOP;
        // amounts: full range, short steps, plain degrees, range corners
        case ($urandom_range(3))
          0: amt = 16'($urandom);
          1: amt = 16'($urandom_range(400)) - 16'd200;
          2: amt = 16'($urandom_range(360));
          default: begin
            case ($urandom_range(4))
              0:       amt = 16'h7FFF;
              1:       amt = 16'h8000;
              2:       amt = 16'hFFFF;
              3:       amt = 16'h0001;
              default: amt = 16'h0000;
            endcase
          end
        endcase
        offer_cmd(op, amt, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
      end
      drain();
    end

    // catch any stray result after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_mismatch == 0 && n_pending == 0) $display("PASS turtle_pen_stepper");
    else $display("FAIL turtle_pen_stepper");
    $finish;
  end

endmodule
